/* src/vti_pkg.sv */
package vti_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // register offsets
  localparam logic [3:0] ADDR_T1CL = 4'h4;
  localparam logic [3:0] ADDR_T1CH = 4'h5;
  localparam logic [3:0] ADDR_T1LL = 4'h6;
  localparam logic [3:0] ADDR_T1LH = 4'h7;
  localparam logic [3:0] ADDR_T2CL = 4'h8;
  localparam logic [3:0] ADDR_T2CH = 4'h9;
  localparam logic [3:0] ADDR_ACR  = 4'hB;
  localparam logic [3:0] ADDR_IFR  = 4'hD;
  localparam logic [3:0] ADDR_IER  = 4'hE;

  // bit positions in IFR/IER and ACR
  localparam int FLAG_T1_BIT      = 6;
  localparam int FLAG_T2_BIT      = 5;
  localparam int IER_SET_BIT      = 7;
  localparam int ACR_T1_FREE_BIT  = 6;
  localparam int ACR_T2_PULSE_BIT = 5;

  localparam int FLAG_W = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] reg_address;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       handled;
    logic       irq;
  } result_t;

  // handshake between the stages
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

/* src/vti_in_stage.sv */
module vti_in_stage
  import vti_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // the held beat leaves whenever the result register can take it
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* src/vti_core.sv */
module vti_core
  import vti_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  item_t      item,
  output result_t    result
);

  logic              fire;
  logic [15:0]       t1_count_r, t1_count_nxt;
  logic [15:0]       t1_reload_r, t1_reload_nxt;
  logic              t1_running_r, t1_running_nxt;
  logic              t1_skip_r, t1_skip_nxt;
  logic              t1_reload_due_r, t1_reload_due_nxt;
  logic              t1_silenced_r, t1_silenced_nxt;
  logic [15:0]       t2_count_r, t2_count_nxt;
  logic [7:0]        t2_low_byte_r, t2_low_byte_nxt;
  logic              t2_running_r, t2_running_nxt;
  logic              t2_skip_r, t2_skip_nxt;
  logic              t2_silenced_r, t2_silenced_nxt;
  logic [7:0]        acr_r, acr_nxt;
  logic [FLAG_W-1:0] flag_r, flag_nxt;
  logic [FLAG_W-1:0] enable_r, enable_nxt;
  logic [15:0]       t1_dec;
  logic [15:0]       t2_dec;
  logic              irq_now;
  logic [7:0]        rd;
  logic              hit;
  logic [7:0]        d;

  assign fire    = ctl.valid && ctl.advance;
  assign t1_dec  = t1_count_r - 16'd1;
  assign t2_dec  = t2_count_r - 16'd1;
  assign irq_now = |(flag_r & enable_r);
  assign d       = item.write_data;

  always_comb begin
    t1_count_nxt      = t1_count_r;
    t1_reload_nxt     = t1_reload_r;
    t1_running_nxt    = t1_running_r;
    t1_skip_nxt       = t1_skip_r;
    t1_reload_due_nxt = t1_reload_due_r;
    t1_silenced_nxt   = t1_silenced_r;
    t2_count_nxt      = t2_count_r;
    t2_low_byte_nxt   = t2_low_byte_r;
    t2_running_nxt    = t2_running_r;
    t2_skip_nxt       = t2_skip_r;
    t2_silenced_nxt   = t2_silenced_r;
    acr_nxt           = acr_r;
    flag_nxt          = flag_r;
    enable_nxt        = enable_r;
    rd                = 8'd0;
    hit               = 1'b0;
    if (fire) begin
      case (item.kind)
        KIND_TICK: begin
          if (t1_running_r) begin
            // a pending reload uses up this tick in place of a decrement
            if (t1_reload_due_r) begin
              t1_count_nxt      = t1_reload_r;
              t1_reload_due_nxt = 1'b0;
              t1_skip_nxt       = 1'b0;
            end else if (t1_skip_r) begin
              t1_skip_nxt = 1'b0;
            end else begin
              t1_count_nxt = t1_dec;
              if ((t1_dec == 16'd0) && !t1_silenced_r) begin
                flag_nxt[FLAG_T1_BIT] = 1'b1;
                if (acr_r[ACR_T1_FREE_BIT]) begin
                  t1_reload_due_nxt = 1'b1;
                end else begin
                  t1_silenced_nxt = 1'b1;
                end
              end
            end
          end
          // pulse-count mode freezes timer 2, skip included
          if (t2_running_r && !acr_r[ACR_T2_PULSE_BIT]) begin
            if (t2_skip_r) begin
              t2_skip_nxt = 1'b0;
            end else begin
              t2_count_nxt = t2_dec;
              if ((t2_dec == 16'd0) && !t2_silenced_r) begin
                flag_nxt[FLAG_T2_BIT] = 1'b1;
                t2_silenced_nxt       = 1'b1;
              end
            end
          end
        end
        KIND_READ: begin
          hit = 1'b1;
          case (item.reg_address)
            ADDR_T1CL: begin
              flag_nxt[FLAG_T1_BIT] = 1'b0;
              rd = t1_count_r[7:0];
            end
            ADDR_T1CH: rd = t1_count_r[15:8];
            ADDR_T1LL: rd = t1_reload_r[7:0];
            ADDR_T1LH: rd = t1_reload_r[15:8];
            ADDR_T2CL: begin
              flag_nxt[FLAG_T2_BIT] = 1'b0;
              rd = t2_count_r[7:0];
            end
            ADDR_T2CH: rd = t2_count_r[15:8];
            ADDR_ACR:  rd = acr_r;
            ADDR_IFR:  rd = {irq_now, flag_r};
            ADDR_IER:  rd = {1'b1, enable_r};
            default:   hit = 1'b0;
          endcase
        end
        KIND_WRITE: begin
          hit = 1'b1;
          case (item.reg_address)
            ADDR_T1CL, ADDR_T1LL: t1_reload_nxt[7:0] = d;
            ADDR_T1CH: begin
              t1_reload_nxt         = {d, t1_reload_r[7:0]};
              t1_count_nxt          = {d, t1_reload_r[7:0]};
              t1_running_nxt        = 1'b1;
              t1_skip_nxt           = 1'b1;
              t1_reload_due_nxt     = 1'b0;
              t1_silenced_nxt       = 1'b0;
              flag_nxt[FLAG_T1_BIT] = 1'b0;
            end
            ADDR_T1LH: begin
              t1_reload_nxt[15:8]   = d;
              flag_nxt[FLAG_T1_BIT] = 1'b0;
            end
            ADDR_T2CL: t2_low_byte_nxt = d;
            ADDR_T2CH: begin
              t2_count_nxt          = {d, t2_low_byte_r};
              t2_running_nxt        = 1'b1;
              t2_skip_nxt           = 1'b1;
              t2_silenced_nxt       = 1'b0;
              flag_nxt[FLAG_T2_BIT] = 1'b0;
            end
            ADDR_ACR: acr_nxt = d;
            ADDR_IFR: flag_nxt = flag_r & ~d[FLAG_W-1:0];
            ADDR_IER: begin
              if (d[IER_SET_BIT]) begin
                enable_nxt = enable_r | d[FLAG_W-1:0];
              end else begin
                enable_nxt = enable_r & ~d[FLAG_W-1:0];
              end
            end
            default: hit = 1'b0;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign result.read_data = rd;
  assign result.handled   = hit;
  assign result.irq       = |(flag_nxt & enable_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_count_r      <= '0;
      t1_reload_r     <= '0;
      t1_running_r    <= 1'b0;
      t1_skip_r       <= 1'b0;
      t1_reload_due_r <= 1'b0;
      t1_silenced_r   <= 1'b0;
      t2_count_r      <= '0;
      t2_low_byte_r   <= '0;
      t2_running_r    <= 1'b0;
      t2_skip_r       <= 1'b0;
      t2_silenced_r   <= 1'b0;
      acr_r           <= '0;
      flag_r          <= '0;
      enable_r        <= '0;
    end else begin
      t1_count_r      <= t1_count_nxt;
      t1_reload_r     <= t1_reload_nxt;
      t1_running_r    <= t1_running_nxt;
      t1_skip_r       <= t1_skip_nxt;
      t1_reload_due_r <= t1_reload_due_nxt;
      t1_silenced_r   <= t1_silenced_nxt;
      t2_count_r      <= t2_count_nxt;
      t2_low_byte_r   <= t2_low_byte_nxt;
      t2_running_r    <= t2_running_nxt;
      t2_skip_r       <= t2_skip_nxt;
      t2_silenced_r   <= t2_silenced_nxt;
      acr_r           <= acr_nxt;
      flag_r          <= flag_nxt;
      enable_r        <= enable_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_due_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    t1_reload_due_r |-> t1_running_r)
    else $error("t1 reload pending while stopped");

  a_due_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    t1_reload_due_r |-> !t1_skip_r && !t1_silenced_r)
    else $error("t1 reload pending with skip or silenced");

  a_t2_sil_run: assert property (@(posedge clk) disable iff (!rst_n)
    t2_silenced_r |-> t2_running_r)
    else $error("t2 silenced while never started");

  a_t1_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item.kind == KIND_WRITE) && (item.reg_address == ADDR_T1CH))
    |=> t1_running_r && t1_skip_r && !flag_r[FLAG_T1_BIT])
    else $error("t1 start write not taken");
`endif

endmodule

/* src/vti_out_stage.sv */
module vti_out_stage
  import vti_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_valid,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

/* src/via_timer_interrupt_block.sv */
// throughput: one beat per cycle; input register, one pass of timer logic, result register
// a stalled output holds the result register and the input register backs up behind it
// reset (rst_n low, synchronous) clears both timers, the latch, ACR, IFR, IER
// and both stage valid bits
module via_timer_interrupt_block
  import vti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_address [3:0], write_data [11:4], zeros
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data [7:0], irq [8], zeros
  output logic        out_tuser   // handled [0]
);

  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       advance;
  stage_ctl_t ctl;
  result_t    core_result;
  result_t    out_result;

  assign in_item.kind        = in_tuser;
  assign in_item.reg_address = in_tdata[3:0];
  assign in_item.write_data  = in_tdata[11:4];

  assign ctl.valid   = s1_valid;
  assign ctl.advance = advance;

  vti_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  vti_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (s1_item),
    .result (core_result)
  );

  vti_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (core_result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {7'd0, out_result.irq, out_result.read_data};
  assign out_tuser = out_result.handled;

endmodule

/* test/tb_via_timer_interrupt_block.sv */
`timescale 1ns / 1ps

module tb_via_timer_interrupt_block;
  import vti_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // kind code the block treats as a no-op
  localparam logic [1:0] KIND_NONE = 2'd3;
  // offsets the timer block does not decode
  localparam logic [3:0] ADDR_ORB   = 4'h0;
  localparam logic [3:0] ADDR_PCR   = 4'hC;
  localparam logic [3:0] ADDR_ORANH = 4'hF;

  typedef struct packed {
    item_t   beat;
    logic    typed;
    result_t res;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  via_timer_interrupt_block DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // timer and interrupt state mirrored from the block
  logic [15:0]       t1_cnt = '0;
  logic [15:0]       t1_latch = '0;
  logic              t1_run = 1'b0;
  logic              t1_hold = 1'b0;
  logic              t1_reload_pend = 1'b0;
  logic              t1_quiet = 1'b0;
  logic [15:0]       t2_cnt = '0;
  logic [7:0]        t2_low = '0;
  logic              t2_run = 1'b0;
  logic              t2_hold = 1'b0;
  logic              t2_quiet = 1'b0;
  logic [7:0]        acr_bits = '0;
  logic [FLAG_W-1:0] ifr_bits = '0;
  logic [FLAG_W-1:0] ier_bits = '0;

  result_t     pending_results[$];
  script_row_t script [SCRIPT_LEN];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic void timer1_tick();
    if (!t1_run) return;
    if (t1_reload_pend) begin
      t1_cnt         = t1_latch;
      t1_reload_pend = 1'b0;
      t1_hold        = 1'b1;
    end
    if (t1_hold) begin
      t1_hold = 1'b0;
    end else begin
      t1_cnt = t1_cnt - 16'd1;
      if (t1_cnt == 16'd0 && !t1_quiet) begin
        ifr_bits[FLAG_T1_BIT] = 1'b1;
        if (acr_bits[ACR_T1_FREE_BIT]) t1_reload_pend = 1'b1;
        else t1_quiet = 1'b1;
      end
    end
  endfunction

  function automatic void timer2_tick();
    if (!t2_run || acr_bits[ACR_T2_PULSE_BIT]) return;
    if (t2_hold) begin
      t2_hold = 1'b0;
    end else begin
      t2_cnt = t2_cnt - 16'd1;
      if (t2_cnt == 16'd0 && !t2_quiet) begin
        ifr_bits[FLAG_T2_BIT] = 1'b1;
        t2_quiet = 1'b1;
      end
    end
  endfunction

  function automatic result_t via_access(item_t it);
    result_t    r;
    logic [7:0] d;
    r = '0;
    d = it.write_data;
    case (it.kind)
      KIND_TICK: begin
        timer1_tick();
        timer2_tick();
      end
      KIND_READ: begin
        r.handled = 1'b1;
        case (it.reg_address)
          ADDR_T1CL: begin
            ifr_bits[FLAG_T1_BIT] = 1'b0;
            r.read_data = t1_cnt[7:0];
          end
          ADDR_T1CH: r.read_data = t1_cnt[15:8];
          ADDR_T1LL: r.read_data = t1_latch[7:0];
          ADDR_T1LH: r.read_data = t1_latch[15:8];
          ADDR_T2CL: begin
            ifr_bits[FLAG_T2_BIT] = 1'b0;
            r.read_data = t2_cnt[7:0];
          end
          ADDR_T2CH: r.read_data = t2_cnt[15:8];
          ADDR_ACR:  r.read_data = acr_bits;
          ADDR_IFR:  r.read_data = {|(ifr_bits & ier_bits), ifr_bits};
          ADDR_IER:  r.read_data = {1'b1, ier_bits};
          default:   r.handled = 1'b0;
        endcase
      end
      KIND_WRITE: begin
        r.handled = 1'b1;
        case (it.reg_address)
          ADDR_T1CL, ADDR_T1LL: t1_latch[7:0] = d;
          ADDR_T1CH: begin
            t1_latch[15:8]        = d;
            t1_cnt                = t1_latch;
            t1_run                = 1'b1;
            t1_hold               = 1'b1;
            t1_reload_pend        = 1'b0;
            t1_quiet              = 1'b0;
            ifr_bits[FLAG_T1_BIT] = 1'b0;
          end
          ADDR_T1LH: begin
            t1_latch[15:8]        = d;
            ifr_bits[FLAG_T1_BIT] = 1'b0;
          end
          ADDR_T2CL: t2_low = d;
          ADDR_T2CH: begin
            t2_cnt                = {d, t2_low};
            t2_run                = 1'b1;
            t2_hold               = 1'b1;
            t2_quiet              = 1'b0;
            ifr_bits[FLAG_T2_BIT] = 1'b0;
          end
          ADDR_ACR: acr_bits = d;
          ADDR_IFR: ifr_bits = ifr_bits & ~d[FLAG_W-1:0];
          ADDR_IER: begin
            if (d[IER_SET_BIT]) ier_bits = ier_bits | d[FLAG_W-1:0];
            else ier_bits = ier_bits & ~d[FLAG_W-1:0];
          end
          default: r.handled = 1'b0;
        endcase
      end
      default: ;
    endcase
    r.irq = |(ifr_bits & ier_bits);
    return r;
  endfunction

  function automatic logic [3:0] timer_reg();
    case ($urandom_range(8))
      0:       return ADDR_T1CL;
      1:       return ADDR_T1CH;
      2:       return ADDR_T1LL;
      3:       return ADDR_T1LH;
      4:       return ADDR_T2CL;
      5:       return ADDR_T2CH;
      6:       return ADDR_ACR;
      7:       return ADDR_IFR;
      default: return ADDR_IER;
    endcase
  endfunction

  // mostly ticks with timer programming of short counts so that flags fire often
  function automatic item_t random_access();
    item_t it;
    int    pick;
    pick           = $urandom_range(99);
    it.kind        = KIND_TICK;
    it.reg_address = 4'($urandom_range(15));
    it.write_data  = 8'($urandom_range(255));
    if (pick < 5) begin
      it.kind = 2'($urandom_range(3));
    end else if (pick < 55) begin
      it.kind = KIND_TICK;
    end else if (pick < 75) begin
      it.kind = KIND_READ;
      if ($urandom_range(9) != 0) it.reg_address = timer_reg();
    end else begin
      it.kind = KIND_WRITE;
      if ($urandom_range(9) != 0) it.reg_address = timer_reg();
      case (it.reg_address)
        ADDR_T1CL, ADDR_T1LL, ADDR_T2CL:
          if ($urandom_range(3) != 0) it.write_data = 8'($urandom_range(12));
        ADDR_T1CH, ADDR_T1LH, ADDR_T2CH:
          if ($urandom_range(4) != 0) it.write_data = 8'h00;
        default: ;
      endcase
    end
    return it;
  endfunction

  // called and returns at a falling edge; valid stays high into the next beat
  task automatic send_beat(item_t it, logic typed, result_t typed_res);
    result_t r;
    while (!no_gaps && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, it.write_data, it.reg_address};
    in_tuser  <= it.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = via_access(it);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tuser, out_tdata[8]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected beat: read_data %02h handled %0b irq %0b",
                   got.read_data, got.handled, got.irq);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: read_data %02h/%02h handled %0b/%0b irq %0b/%0b (exp/act)",
                     want.read_data, got.read_data, want.handled, got.handled,
                     want.irq, got.irq);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;

    // beat {kind, offset, data}, typed flag, expected {read_data, handled, irq}
    script[0]  = {KIND_READ,  ADDR_IER,   8'h00, 1'b1, 8'h80, 1'b1, 1'b0};
    script[1]  = {KIND_READ,  ADDR_IFR,   8'h00, 1'b1, 8'h00, 1'b1, 1'b0};
    script[2]  = {KIND_READ,  ADDR_ORB,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0};
    script[3]  = {KIND_NONE,  ADDR_ORANH, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0};
    script[4]  = {KIND_WRITE, ADDR_PCR,   8'hFF, 1'b1, 8'h00, 1'b0, 1'b0};
    script[5]  = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0};
    script[6]  = {KIND_WRITE, ADDR_IER,   8'hFF, 1'b1, 8'h00, 1'b1, 1'b0};
    script[7]  = {KIND_WRITE, ADDR_T1CL,  8'h02, 1'b1, 8'h00, 1'b1, 1'b0};
    script[8]  = {KIND_WRITE, ADDR_T1CH,  8'h00, 1'b0, 10'h000};
    script[9]  = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[10] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[11] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[12] = {KIND_READ,  ADDR_IFR,   8'h00, 1'b0, 10'h000};
    script[13] = {KIND_READ,  ADDR_T1CL,  8'h00, 1'b0, 10'h000};
    // T1 free-running, T2 counting pulses, both reloaded with short counts
    script[14] = {KIND_WRITE, ADDR_ACR,   8'h60, 1'b0, 10'h000};
    script[15] = {KIND_WRITE, ADDR_T1CH,  8'h00, 1'b0, 10'h000};
    script[16] = {KIND_WRITE, ADDR_T2CL,  8'h01, 1'b0, 10'h000};
    script[17] = {KIND_WRITE, ADDR_T2CH,  8'h00, 1'b0, 10'h000};
    script[18] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[19] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[20] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[21] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[22] = {KIND_WRITE, ADDR_ACR,   8'h00, 1'b0, 10'h000};
    script[23] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[24] = {KIND_TICK,  ADDR_ORB,   8'h00, 1'b0, 10'h000};
    script[25] = {KIND_WRITE, ADDR_IFR,   8'hFF, 1'b0, 10'h000};
    script[26] = {KIND_WRITE, ADDR_IER,   8'h7F, 1'b0, 10'h000};
    script[27] = {KIND_WRITE, ADDR_T1LH,  8'hFF, 1'b0, 10'h000};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_beat(script[i].beat, script[i].typed, script[i].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_gaps = (i >= 700 && i < 950);
      if (i == 400) begin
        // hold off until the pipeline has drained
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      it = random_access();
      send_beat(it, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
